@@ design/qsb_pkg.sv @@
// Shared types, codes and helper functions for the quality score binning block.
`default_nettype none

package qsb_pkg;

  localparam int unsigned VAL_W  = 7;
  localparam int unsigned MANT_W = 32;

  typedef enum logic [1:0] {
    REG_KIND   = 2'd0,
    REG_STEP   = 2'd1,
    REG_OFFSET = 2'd2,
    REG_MAX    = 2'd3
  } reg_idx_t;

  localparam logic FUNC_FWD     = 1'b0;
  localparam logic FUNC_REV     = 1'b1;
  localparam logic KIND_LOG     = 1'b0;
  localparam logic KIND_UNIFORM = 1'b1;

  // One score handed to the region pipeline: mantissa index and saturated decade.
  typedef struct packed {
    logic       valid;
    logic [3:0] j;
    logic [1:0] d;
  } qsb_tap_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] region;
  } qsb_region_t;

  // 10^(-j/10) in Q1.31, rounded
  function automatic logic [MANT_W-1:0] decade_mant(input logic [3:0] j);
    logic [MANT_W-1:0] m;
    begin
      case (j)
        4'd0:    m = 32'd2147483648;
        4'd1:    m = 32'd1705806895;
        4'd2:    m = 32'd1354970580;
        4'd3:    m = 32'd1076291389;
        4'd4:    m = 32'd854928639;
        4'd5:    m = 32'd679093957;
        4'd6:    m = 32'd539423504;
        4'd7:    m = 32'd428479320;
        4'd8:    m = 32'd340353221;
        4'd9:    m = 32'd270352174;
        default: m = 32'd0;
      endcase
      return m;
    end
  endfunction

  // floor(r/10) by reciprocal, exact for every 7-bit r
  function automatic logic [VAL_W-1:0] div10(input logic [VAL_W-1:0] r);
    logic [14:0] p;
    begin
      p = 15'(r) * 15'd205;
      return p[14:11] == 4'd0 ? 7'd0 : 7'(p >> 11);
    end
  endfunction

endpackage

`default_nettype wire

@@ design/qsb_div.sv @@
// Restoring divider for the log-mode bin index, one quotient bit per cycle.
`default_nettype none

module qsb_div (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [6:0] dividend,
  input  wire logic [6:0] divisor,
  output logic            done,
  output logic [6:0]      quotient
);

  logic       busy_r;
  logic       done_r;
  logic [2:0] cnt_r;
  logic [7:0] rem_r;
  logic [6:0] quo_r;
  logic [6:0] dvs_r;

  logic [7:0] rem_sh;
  logic       fits;

  assign rem_sh = {rem_r[6:0], quo_r[6]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= busy_r && (cnt_r == 3'd6);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd6) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // dividend bits shift out of quo_r as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 8'd0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_r <= {quo_r[5:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ design/qsb_region.sv @@
// Probability region pipeline: mantissa ROM read, scale multiply, decade shift and clamp.
`default_nettype none

module qsb_region (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              flush,
  input  wire logic [6:0]        step,
  input  wire qsb_pkg::qsb_tap_t tap,
  output qsb_pkg::qsb_region_t   reg_out
);

  // ROM stage: registered read of the decade mantissa
  logic                        a_valid_r;
  logic [qsb_pkg::MANT_W-1:0]  a_mant_r;
  logic [1:0]                  a_d_r;

  // multiply stage
  logic                        b_valid_r;
  logic [qsb_pkg::VAL_W-1:0]   b_val_r;
  logic [1:0]                  b_d_r;

  logic [38:0]                 prod;
  logic [qsb_pkg::VAL_W-1:0]   q_div1;
  logic [qsb_pkg::VAL_W-1:0]   q_div2;
  logic [qsb_pkg::VAL_W-1:0]   q_sh;
  logic [qsb_pkg::VAL_W-1:0]   lim;

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= tap.valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_mant_r <= qsb_pkg::decade_mant(tap.j);
    a_d_r    <= tap.d;
    b_val_r  <= prod[37:31];
    b_d_r    <= a_d_r;
  end

  // mantissa <= 2^31 and step < 2^7, so bit 38 never sets
  assign prod = 39'(a_mant_r) * 39'(step);

  assign q_div1 = qsb_pkg::div10(b_val_r);
  assign q_div2 = qsb_pkg::div10(q_div1);

  // a 7-bit value is zero after three divisions by ten
  always_comb begin
    case (b_d_r)
      2'd0:    q_sh = b_val_r;
      2'd1:    q_sh = q_div1;
      2'd2:    q_sh = q_div2;
      default: q_sh = 7'd0;
    endcase
  end

  assign lim            = step - 7'd1;
  assign reg_out.valid  = b_valid_r;
  assign reg_out.region = (q_sh > lim) ? lim : q_sh;

endmodule

`default_nettype wire

@@ design/quality_score_binning.sv @@
// Quality score binning top level: config registers, item sequencer and output register.
//
// Usage:
//   cfg_*  : register writes (index 0 kind, 1 step, 2 offset, 3 max), always ready.
//            Write only while no item is in flight.
//   in_*   : one request per item; tuser[0] selects symbol-to-bin or bin-to-symbol,
//            tdata[6:0] carries the symbol or bin. One item is worked at a time.
//   out_*  : one answer per item; tdata[6:0] is the bin or symbol, tuser[0] says
//            whether the mapping is defined (tdata is zero when it is not).
// Item flow, accept to out_tvalid:
//   log reverse requests and those that fail the entry checks go straight to the
//   answer; log forward runs the restoring divider; uniform walks n scores from the
//   offset (up to SYMBOL_COUNT), one score per cycle through the ROM / multiply /
//   region pipeline. in_tready returns at the edge that loads the output register.
// Reset returns the registers to kind 0, step 8, offset 33, max 126 and
// empties the sequencer and output register. While out_tready is low the
// answer holds in the output register; the next item is still taken and
// worked, and its answer waits until the register frees up.
`default_nettype none

module quality_score_binning #(
  parameter int unsigned SYMBOL_COUNT = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [6:0] value, [7] zero pad
  input  wire logic [0:0] in_tuser,   // [0] func
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] result, [7] zero pad
  output logic [0:0]      out_tuser   // [0] valid_res
);

  localparam int unsigned CW = ($clog2(SYMBOL_COUNT) + 1 > 8) ?
                               $clog2(SYMBOL_COUNT) + 1 : 8;
  localparam logic [CW-1:0] SC_C = CW'(SYMBOL_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_SCAN,
    S_DONE
  } state_t;

  state_t      state_r;

  logic        kind_r;
  logic [6:0]  step_r;
  logic [6:0]  offset_r;
  logic [6:0]  max_r;

  logic        func_r;
  logic [6:0]  value_r;
  logic [6:0]  res_r;
  logic        ok_r;

  logic [3:0]  j_r;
  logic [1:0]  d_r;
  logic [CW-1:0] tally_i_r;
  logic [CW-1:0] bin_r;
  logic [6:0]  prev_r;
  logic        first_r;

  logic        out_valid_r;
  logic [6:0]  out_result_r;
  logic        out_ok_r;

  logic [CW-1:0] v_ext;
  logic [CW-1:0] off_ext;
  logic [CW-1:0] max_ext;
  logic        in_range;
  logic        fwd_log_ok;
  logic [13:0] rev_sum;
  logic        rev_log_ok;
  logic        uni_fwd_ok;
  logic        uni_rev_ok;

  logic        div_start;
  logic        div_done;
  logic [6:0]  div_quo;

  qsb_pkg::qsb_tap_t    tap;
  qsb_pkg::qsb_region_t ro;

  logic [CW-1:0] bin_new;
  logic        hit_fwd;
  logic        hit_rev;
  logic        stop_rev;
  logic        scan_end;
  logic        out_free;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);

  assign v_ext    = CW'(value_r);
  assign off_ext  = CW'(offset_r);
  assign max_ext  = CW'(max_r);
  assign in_range = v_ext < SC_C;

  assign fwd_log_ok = (v_ext >= off_ext) && in_range &&
                      ((v_ext <= max_ext + CW'(1)) || (value_r == offset_r));
  assign rev_sum    = 14'(offset_r) + 14'(value_r - 7'd1) * 14'(step_r);
  assign rev_log_ok = (value_r != 7'd0) && in_range && (rev_sum <= 14'(max_r));
  assign uni_fwd_ok = (v_ext >= off_ext) && in_range;
  assign uni_rev_ok = off_ext < SC_C;

  assign div_start = (state_r == S_START) && (step_r != 7'd0) &&
                     (kind_r == qsb_pkg::KIND_LOG) && (func_r == qsb_pkg::FUNC_FWD) &&
                     fwd_log_ok;

  qsb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (value_r - offset_r),
    .divisor  (step_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // uniform walk: tally bins as regions come out of the pipeline in order
  assign bin_new  = first_r ? CW'(1) : ((ro.region != prev_r) ? bin_r + CW'(1) : bin_r);
  assign hit_fwd  = tally_i_r == v_ext;
  assign hit_rev  = bin_new == v_ext;
  assign stop_rev = (tally_i_r > max_ext) || (tally_i_r == SC_C - CW'(1));
  assign scan_end = (state_r == S_SCAN) && ro.valid &&
                    ((func_r == qsb_pkg::FUNC_FWD) ? hit_fwd : (hit_rev || stop_rev));

  assign tap.valid = (state_r == S_SCAN) && !scan_end;
  assign tap.j     = j_r;
  assign tap.d     = d_r;

  qsb_region u_region (
    .clk     (clk),
    .rst_n   (rst_n),
    .flush   (scan_end),
    .step    (step_r),
    .tap     (tap),
    .reg_out (ro)
  );

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= qsb_pkg::KIND_LOG;
      step_r      <= 7'd8;
      offset_r    <= 7'd33;
      max_r       <= 7'd126;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          qsb_pkg::REG_KIND:   kind_r   <= cfg_data[0];
          qsb_pkg::REG_STEP:   step_r   <= cfg_data;
          qsb_pkg::REG_OFFSET: offset_r <= cfg_data;
          qsb_pkg::REG_MAX:    max_r    <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            func_r  <= in_tuser[0];
            value_r <= in_tdata[6:0];
            state_r <= S_START;
          end
        end
        S_START: begin
          j_r       <= 4'd0;
          d_r       <= 2'd0;
          tally_i_r <= off_ext;
          first_r   <= 1'b1;
          if (div_start) begin
            res_r   <= 7'd0;
            ok_r    <= 1'b0;
            state_r <= S_DIV;
          end else if ((step_r != 7'd0) && (kind_r == qsb_pkg::KIND_UNIFORM) &&
                       ((func_r == qsb_pkg::FUNC_FWD) ? uni_fwd_ok : uni_rev_ok)) begin
            res_r   <= 7'd0;
            ok_r    <= 1'b0;
            state_r <= S_SCAN;
          end else if ((step_r != 7'd0) && (kind_r == qsb_pkg::KIND_LOG) &&
                       (func_r == qsb_pkg::FUNC_REV) && rev_log_ok) begin
            res_r   <= rev_sum[6:0];
            ok_r    <= 1'b1;
            state_r <= S_DONE;
          end else begin
            res_r   <= 7'd0;
            ok_r    <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            // bin index 128 does not fit the result field
            res_r   <= (div_quo == 7'd127) ? 7'd0 : div_quo + 7'd1;
            ok_r    <= div_quo != 7'd127;
            state_r <= S_DONE;
          end
        end
        S_SCAN: begin
          if (tap.valid) begin
            j_r <= (j_r == 4'd9) ? 4'd0 : j_r + 4'd1;
            if (j_r == 4'd9 && d_r != 2'd3) begin
              d_r <= d_r + 2'd1;
            end
          end
          if (ro.valid) begin
            first_r   <= 1'b0;
            bin_r     <= bin_new;
            prev_r    <= ro.region;
            tally_i_r <= tally_i_r + CW'(1);
          end
          if (scan_end) begin
            state_r <= S_DONE;
            if (func_r == qsb_pkg::FUNC_FWD) begin
              res_r <= bin_new[6:0];
              ok_r  <= 1'b1;
            end else if (hit_rev) begin
              res_r <= tally_i_r[6:0];
              ok_r  <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_result_r <= res_r;
            out_ok_r     <= ok_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_result_r};
  assign out_tuser  = out_ok_r;

endmodule

`default_nettype wire

@@ design/qsb_checker.sv @@
// Port-level checker for the quality score binning block, bound to the top level.
`default_nettype none

module qsb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [0:0] out_tuser
);

  // a held answer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("answer changed while stalled");

  // undefined mapping reads as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 8'd0)
    else $error("nonzero result with valid_res low");

  // one item at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("answer pending after reset");

endmodule

bind quality_score_binning qsb_checker u_qsb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

@@ tb/tb_quality_score_binning.sv @@
// Self-checking testbench for quality_score_binning: directed corner items, then random phases.
module tb_quality_score_binning;
  import qsb_pkg::*;

  localparam int unsigned SYMBOLS = 128;

  // 10^(-j/10) in Q1.31, one decade
  localparam longint unsigned DECADE_MANT [10] = '{
    64'd2147483648, 64'd1705806895, 64'd1354970580, 64'd1076291389, 64'd854928639,
    64'd679093957, 64'd539423504, 64'd428479320, 64'd340353221, 64'd270352174
  };

  typedef struct packed {
    logic       valid;
    logic [6:0] result;
  } bin_answer_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] step;
    logic [6:0] offset;
    logic [6:0] limit;
  } bin_setup_t;

  // one directed row: either a register write or an item, with an optional typed answer
  typedef struct packed {
    logic       is_reg;
    reg_idx_t   idx;
    logic [6:0] data;
    logic       func;
    logic [6:0] value;
    logic       typed;
    logic [6:0] res;
    logic       ok;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 36;
  localparam plan_row_t DIRECTED [PLAN_ROWS] = '{
    // reset setup: log, step 8, offset 33, max 126
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd0,   1'b1, 7'd0,   1'b0}, // below offset
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd32,  1'b1, 7'd0,   1'b0},
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd33,  1'b1, 7'd1,   1'b1},
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd41,  1'b1, 7'd2,   1'b1},
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd127, 1'b1, 7'd12,  1'b1}, // max+1 still binned
    '{1'b0, REG_KIND,   7'd0,   FUNC_REV, 7'd0,   1'b1, 7'd0,   1'b0}, // bin zero
    '{1'b0, REG_KIND,   7'd0,   FUNC_REV, 7'd1,   1'b1, 7'd33,  1'b1},
    '{1'b0, REG_KIND,   7'd0,   FUNC_REV, 7'd12,  1'b1, 7'd121, 1'b1},
    '{1'b0, REG_KIND,   7'd0,   FUNC_REV, 7'd13,  1'b1, 7'd0,   1'b0}, // past max
    '{1'b0, REG_KIND,   7'd0,   FUNC_REV, 7'd127, 1'b1, 7'd0,   1'b0},
    '{1'b1, REG_KIND,   7'd1,   FUNC_FWD, 7'd0,   1'b0, 7'd0,   1'b0},
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd33,  1'b1, 7'd1,   1'b1},
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd127, 1'b0, 7'd0,   1'b0},
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd0,   1'b1, 7'd0,   1'b0},
    '{1'b0, REG_KIND,   7'd0,   FUNC_REV, 7'd1,   1'b1, 7'd33,  1'b1},
    '{1'b0, REG_KIND,   7'd0,   FUNC_REV, 7'd3,   1'b0, 7'd0,   1'b0},
    '{1'b0, REG_KIND,   7'd0,   FUNC_REV, 7'd127, 1'b0, 7'd0,   1'b0},
    '{1'b1, REG_STEP,   7'd0,   FUNC_FWD, 7'd0,   1'b0, 7'd0,   1'b0}, // zero step
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd50,  1'b1, 7'd0,   1'b0},
    '{1'b0, REG_KIND,   7'd0,   FUNC_REV, 7'd1,   1'b1, 7'd0,   1'b0},
    '{1'b1, REG_STEP,   7'd1,   FUNC_FWD, 7'd0,   1'b0, 7'd0,   1'b0},
    '{1'b1, REG_OFFSET, 7'd0,   FUNC_FWD, 7'd0,   1'b0, 7'd0,   1'b0},
    '{1'b1, REG_MAX,    7'd127, FUNC_FWD, 7'd0,   1'b0, 7'd0,   1'b0},
    '{1'b1, REG_KIND,   7'd0,   FUNC_FWD, 7'd0,   1'b0, 7'd0,   1'b0},
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd127, 1'b1, 7'd0,   1'b0}, // bin 128 too wide
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd126, 1'b1, 7'd127, 1'b1},
    '{1'b0, REG_KIND,   7'd0,   FUNC_REV, 7'd127, 1'b1, 7'd126, 1'b1},
    '{1'b1, REG_STEP,   7'd4,   FUNC_FWD, 7'd0,   1'b0, 7'd0,   1'b0},
    '{1'b1, REG_OFFSET, 7'd100, FUNC_FWD, 7'd0,   1'b0, 7'd0,   1'b0}, // offset above max
    '{1'b1, REG_MAX,    7'd50,  FUNC_FWD, 7'd0,   1'b0, 7'd0,   1'b0},
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd100, 1'b1, 7'd1,   1'b1},
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd101, 1'b1, 7'd0,   1'b0},
    '{1'b0, REG_KIND,   7'd0,   FUNC_REV, 7'd1,   1'b1, 7'd0,   1'b0},
    '{1'b1, REG_KIND,   7'd1,   FUNC_FWD, 7'd0,   1'b0, 7'd0,   1'b0},
    '{1'b0, REG_KIND,   7'd0,   FUNC_REV, 7'd1,   1'b1, 7'd100, 1'b1},
    '{1'b0, REG_KIND,   7'd0,   FUNC_FWD, 7'd127, 1'b0, 7'd0,   1'b0}
  };

  localparam int unsigned CORNER_COUNT = 8;
  localparam bin_setup_t CORNERS [CORNER_COUNT] = '{
    '{KIND_LOG,     7'd8,   7'd33,  7'd126},
    '{KIND_UNIFORM, 7'd8,   7'd33,  7'd126},
    '{KIND_LOG,     7'd1,   7'd0,   7'd127},
    '{KIND_UNIFORM, 7'd64,  7'd0,   7'd127},
    '{KIND_UNIFORM, 7'd127, 7'd0,   7'd127},
    '{KIND_LOG,     7'd127, 7'd127, 7'd127},
    '{KIND_UNIFORM, 7'd1,   7'd64,  7'd10},
    '{KIND_LOG,     7'd0,   7'd20,  7'd100}
  };

  localparam int unsigned PHASES      = 14;
  localparam int unsigned PHASE_ITEMS = 100;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index  = 2'd0;
  logic [6:0] cfg_data   = 7'd0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'd0;
  logic [0:0] in_tuser   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [0:0] out_tuser;

  // register shadow used by the predictor
  logic       set_kind   = KIND_LOG;
  logic [6:0] set_step   = 7'd8;
  logic [6:0] set_offset = 7'd33;
  logic [6:0] set_max    = 7'd126;

  bin_answer_t pending_answers [$];
  bin_answer_t oldest_answer;
  int unsigned mismatch_count = 0;
  int unsigned sink_left      = 0;
  bit          idle_on        = 1'b1;

  quality_score_binning #(.SYMBOL_COUNT(SYMBOLS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [6:0] value, [7] zero pad
    .in_tuser   (in_tuser),   // [0] func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [6:0] result, [7] zero pad
    .out_tuser  (out_tuser)   // [0] valid_res
  );

  initial forever #2 clk = ~clk;

  initial begin
    #4000000;
    $display("tb_quality_score_binning: errors");
    $finish;
  end

  // probability region of score q: decade mantissa times step, then one /10 per decade, clamped to step - 1
  function automatic int unsigned region_of(int unsigned q, int unsigned step);
    longint unsigned r;
    int unsigned     d;
    r = (DECADE_MANT[q % 10] * longint'(step)) >> 31;
    d = q / 10;
    while (d > 0 && r > 0) begin
      r = r / 10;
      d--;
    end
    if (r > longint'(step - 1)) r = step - 1;
    return int'(r);
  endfunction

  function automatic bin_answer_t predict_binning(logic func, logic [6:0] value);
    bin_answer_t ans;
    int unsigned sym, off, lim, step, b, prev, r, i;
    sym  = value;
    off  = set_offset;
    lim  = set_max;
    step = set_step;
    ans  = '0;
    if (step != 0) begin
      if (set_kind == KIND_LOG && func == FUNC_FWD) begin
        if (sym >= off && (sym <= lim + 1 || sym == off)) begin
          b = (sym - off) / step + 1;
          if (b <= 127) ans = '{1'b1, 7'(b)};
        end
      end else if (set_kind == KIND_LOG) begin
        if (sym >= 1) begin
          b = off + (sym - 1) * step;
          if (b <= lim) ans = '{1'b1, 7'(b)};
        end
      end else begin
        // walk scores up from the offset, opening a bin at each region change
        b    = 1;
        prev = region_of(0, step);
        for (i = off; i < SYMBOLS; i++) begin
          r = region_of(i - off, step);
          if (r != prev) begin
            b++;
            prev = r;
          end
          if (func == FUNC_FWD) begin
            if (i == sym) begin
              ans = '{1'b1, 7'(b)};
              break;
            end
          end else begin
            if (b == sym) begin
              ans = '{1'b1, 7'(i)};
              break;
            end
            if (i > lim) break;
          end
        end
      end
    end
    return ans;
  endfunction

  // register writes wait until every item in flight has answered
  task automatic write_reg(reg_idx_t idx, logic [6:0] data);
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_KIND:   set_kind   = data[0];
      REG_STEP:   set_step   = data;
      REG_OFFSET: set_offset = data;
      REG_MAX:    set_max    = data;
      default:    ;
    endcase
  endtask

  // in_tvalid stays high after the handshake; callers lower it for a gap
  task automatic send_item(logic func, logic [6:0] value, logic typed, bin_answer_t typed_ans);
    cfg_valid <= 1'b0;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, value};
    in_tuser  <= func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_answers.push_back(typed ? typed_ans : predict_binning(func, value));
  endtask

  // result side stalls in bursts, except in phases with idle_on cleared
  always @(posedge clk) begin
    if (!idle_on) begin
      out_tready <= 1'b1;
      sink_left  <= 0;
    end else if (sink_left != 0) begin
      sink_left <= sink_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      sink_left  <= $urandom_range(1, 10) - 1;
    end else begin
      out_tready <= 1'b1;
      sink_left  <= $urandom_range(1, 30);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected item: result %0d valid %0b", out_tdata[6:0], out_tuser[0]);
        mismatch_count++;
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (out_tdata[6:0] !== oldest_answer.result || out_tuser[0] !== oldest_answer.valid) begin
          if (mismatch_count < 10)
            $display("mismatch: expected result %0d valid %0b, got result %0d valid %0b",
                     oldest_answer.result, oldest_answer.valid, out_tdata[6:0], out_tuser[0]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned ph, n, top_sym, span;
    logic        func;
    logic [6:0]  value;
    bin_setup_t  setup;
    bin_answer_t probe;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < PLAN_ROWS; n++) begin
      if (DIRECTED[n].is_reg)
        write_reg(DIRECTED[n].idx, DIRECTED[n].data);
      else
        send_item(DIRECTED[n].func, DIRECTED[n].value, DIRECTED[n].typed,
                  '{DIRECTED[n].ok, DIRECTED[n].res});
    end

    for (ph = 0; ph < PHASES; ph++) begin
      idle_on = (ph != 4 && ph != PHASES - 1);
      if (ph < CORNER_COUNT) begin
        setup = CORNERS[ph];
      end else begin
        setup.kind   = 1'($urandom_range(0, 1));
        setup.step   = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(1, 16));
        setup.offset = 7'($urandom_range(0, 80));
        setup.limit  = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(setup.offset, 127));
      end
      write_reg(REG_KIND, {6'd0, setup.kind});
      write_reg(REG_STEP, setup.step);
      write_reg(REG_OFFSET, setup.offset);
      write_reg(REG_MAX, setup.limit);

      // symbols that take part and the bins they reach
      top_sym = (set_max + 1 > 127) ? 127 : set_max + 1;
      if (top_sym < set_offset) top_sym = set_offset;
      probe = predict_binning(FUNC_FWD, 7'(top_sym));
      span  = probe.valid ? probe.result + 1 : 127;
      if (span > 127) span = 127;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        func = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 7)
          value = (func == FUNC_FWD) ? 7'($urandom_range(set_offset, top_sym))
                                     : 7'($urandom_range(1, span));
        else
          value = 7'($urandom_range(0, 127));
        send_item(func, value, 1'b0, '0);
        if (idle_on && $urandom_range(0, 3) == 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_quality_score_binning: clean");
    else
      $display("tb_quality_score_binning: errors");
    $finish;
  end

endmodule
